>>> hw/rtl/ordered_list_engine_core_assert.svh
// Assertion macros for the ordered list engine.
// Used by ordered_list_engine_core; expects clk and arst_n in scope.
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define OLE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered list engine check failed");
// Next-cycle implication.
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered list engine check failed");
`else
`define OLE_ASSERT_NOW(lbl, ante, cons)
`define OLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/ole_pkg.sv
// Shared types and operation codes for the ordered list engine.
// No dependencies.
package ole_pkg;

	localparam int OP_W  = 2;
	localparam int VAL_W = 32;

	localparam logic [OP_W-1:0] OP_FRONT  = 2'd0;
	localparam logic [OP_W-1:0] OP_BACK   = 2'd1;
	localparam logic [OP_W-1:0] OP_SORTED = 2'd2;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

	typedef logic signed [VAL_W-1:0] val_t;

	// broadcast from the core to every cell
	typedef struct packed {
		logic [OP_W-1:0] op;
		val_t            value;
		logic            wr_en;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/ordered_list_engine_core.sv
// Ordered list engine: a row of DEPTH cells, front at cell 0.
// Flow: an accepted request sets valid_s1 and then done_s2, which drives done; the
// result registers load with done_s2. One request per cycle is taken (busy stays low),
// as the cell shift completes on the accepting edge.
// The result is shown for one cycle and cannot be stalled.
// arst_n clears the entry count and the strobes; entries are not cleared.
module ordered_list_engine_core
	import ole_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OP_W-1:0]            op,
	input  logic signed [VAL_W-1:0]    value,
	output logic                       done,
	output logic                       ok,
	output logic [$clog2(DEPTH+1)-1:0] count,
	output logic signed [VAL_W-1:0]    first_value,
	output logic signed [VAL_W-1:0]    last_value
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	cell_ctrl_t       ctrl;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             is_rm;
	logic             full;
	logic             found;
	logic             wr;

	logic             valid_s1;
	logic             ok_s1;
	logic             done_s2;
	logic             ok_s2;
	logic [CNT_W-1:0] count_s2;
	val_t             first_s2;
	val_t             last_s2;

	val_t entry_w [DEPTH];
	logic seen_w  [DEPTH+1];
	val_t last_w  [DEPTH+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_rm  = (op == OP_REMOVE);
	assign full   = (cnt_q == FULL);
	assign found  = seen_w[DEPTH];
	assign wr     = accept && (is_rm ? found : !full);

	assign ctrl.op    = op;
	assign ctrl.value = value;
	assign ctrl.wr_en = wr;

	assign seen_w[0] = 1'b0;
	assign last_w[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		val_t left_v;
		val_t right_v;
		if (i == 0) begin : g_head
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = entry_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = entry_w[i+1];
		end
		ole_cell #(
			.DEPTH(DEPTH),
			.INDEX(i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.cnt        (cnt_q),
			.left_entry (left_v),
			.right_entry(right_v),
			.seen_in    (seen_w[i]),
			.seen_out   (seen_w[i+1]),
			.last_in    (last_w[i]),
			.last_out   (last_w[i+1]),
			.entry      (entry_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			done_s2  <= 1'b0;
		end else begin
			if (wr) begin
				cnt_q <= is_rm ? cnt_q - 1'b1 : cnt_q + 1'b1;
			end
			valid_s1 <= accept;
			done_s2  <= valid_s1;
		end
	end

	// cells hold the post-request state in the cycle after accept
	always_ff @(posedge clk) begin
		ok_s1    <= wr;
		ok_s2    <= ok_s1;
		count_s2 <= cnt_q;
		first_s2 <= (cnt_q == '0) ? '0 : entry_w[0];
		last_s2  <= last_w[DEPTH];
	end

	assign done        = done_s2;
	assign ok          = ok_s2;
	assign count       = count_s2;
	assign first_value = first_s2;
	assign last_value  = last_s2;

`include "ordered_list_engine_core_assert.svh"

	`OLE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FULL)
	`OLE_ASSERT_NEXT(a_full_hold, accept && !is_rm && full, cnt_q == FULL)
	`OLE_ASSERT_NEXT(a_cnt_hold, !wr, $stable(cnt_q))
	`OLE_ASSERT_NEXT(a_fail_keep, accept && !wr, cnt_q == $past(cnt_q))

endmodule

>>> hw/rtl/ole_cell.sv
// One list cell: holds one entry, compares it against the request value
// and shifts toward or away from its neighbors. Depends on ole_pkg.
module ole_cell
	import ole_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int INDEX = 0
) (
	input  logic                          clk,
	input  cell_ctrl_t                    ctrl,
	input  logic [$clog2(DEPTH+1)-1:0]    cnt,
	input  val_t                          left_entry,
	input  val_t                          right_entry,
	input  logic                          seen_in,
	output logic                          seen_out,
	input  val_t                          last_in,
	output val_t                          last_out,
	output val_t                          entry
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] POS  = CNT_W'(INDEX);
	localparam logic [CNT_W-1:0] NEXT = CNT_W'(INDEX + 1);
	localparam logic IS_HEAD = (INDEX == 0);

	val_t entry_q;
	logic occ;
	logic tail;
	logic lt;
	logic eq;
	logic mark;
	logic after;

	assign occ  = POS < cnt;
	assign tail = occ && (NEXT == cnt);
	assign lt   = occ && ($signed(entry_q) < $signed(ctrl.value));
	assign eq   = occ && (entry_q == ctrl.value);

	// mark the request position; the chain spreads it to every later cell
	always_comb begin
		case (ctrl.op)
			OP_FRONT:  mark = IS_HEAD;
			OP_BACK:   mark = !occ;
			OP_SORTED: mark = !occ || !lt;
			OP_REMOVE: mark = eq;
			default:   mark = 1'b0;
		endcase
	end

	assign after    = seen_in | mark;
	assign seen_out = after;
	assign last_out = tail ? entry_q : last_in;
	assign entry    = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en && after) begin
			if (ctrl.op == OP_REMOVE) begin
				entry_q <= right_entry;
			end else if (!seen_in) begin
				entry_q <= ctrl.value;
			end else begin
				entry_q <= left_entry;
			end
		end
	end

endmodule
